[design/tcgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgs_pkg: shared types and constants of the atom token splitter
// Token kinds, decoder state and the packed payload structs of both channels.
// ----------------------------------------------------------------------------
package tcgs_pkg;

    localparam int LENGTH_BITS = 25;
    localparam int ACC_BITS    = 24;
    localparam int BYTE_BITS   = 8;

    localparam logic [BYTE_BITS-1:0] EMPTY_ATOM_RESET = 8'hFF;

    typedef enum logic [2:0] {
        KIND_TINY    = 3'd0,
        KIND_SHORT   = 3'd1,
        KIND_MEDIUM  = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_CONTROL = 3'd4
    } t_kind;

    // header byte counts after the start byte of a medium or long atom
    localparam logic [1:0] MEDIUM_HDR_BYTES = 2'd1;
    localparam logic [1:0] LONG_HDR_BYTES   = 2'd3;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] bytes_left;
        logic [1:0]             header_bytes_left;
        logic [ACC_BITS-1:0]    length_accum;
        t_kind                  current_kind;
    } t_state;

    typedef struct packed {
        logic [BYTE_BITS-1:0] in_byte;
        logic                 last_byte;
    } t_in;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 keep;
        logic                 token_first;
        logic                 token_last;
        logic [2:0]           token_kind;
        logic                 truncated;
        logic                 stream_end;
    } t_out;

endpackage

[design/tcgs_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgs_decode: per-byte token decode
// Classifies a byte against the current token state and gives the result
// fields and the state after the byte.
// ----------------------------------------------------------------------------
module tcgs_decode (
    input  tcgs_pkg::t_state                   i_state,
    input  tcgs_pkg::t_in                      i_in,
    input  logic [tcgs_pkg::BYTE_BITS-1:0]     i_empty_atom,
    output tcgs_pkg::t_state                   o_state,
    output tcgs_pkg::t_out                     o_res
);
    import tcgs_pkg::*;

    localparam int WIDE_BITS = 33;
    localparam logic [WIDE_BITS-1:0] LEFT_MAX = WIDE_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [BYTE_BITS-1:0]   b;
    logic                   boundary;
    logic [ACC_BITS-1:0]    shifted_acc;
    logic [WIDE_BITS-1:0]   acc_wide;
    logic [LENGTH_BITS-1:0] sat_len;
    logic                   first;
    logic                   last;
    logic                   keep;
    t_state                 nxt;

    assign b           = i_in.in_byte;
    assign boundary    = (i_state.bytes_left == '0) && (i_state.header_bytes_left == 2'd0);
    assign shifted_acc = {i_state.length_accum[ACC_BITS-BYTE_BITS-1:0], b};
    assign acc_wide    = WIDE_BITS'(shifted_acc);
    // lengths beyond the counter range saturate
    assign sat_len     = (acc_wide > LEFT_MAX) ? LENGTH_BITS'(LEFT_MAX)
                                               : LENGTH_BITS'(acc_wide);

    always_comb begin
        nxt   = i_state;
        first = 1'b0;
        last  = 1'b0;
        keep  = 1'b1;
        if (boundary) begin
            first = 1'b1;
            if (!b[7]) begin
                nxt.current_kind = KIND_TINY;
                last = 1'b1;
            end else if (!b[6]) begin
                nxt.current_kind = KIND_SHORT;
                nxt.bytes_left   = LENGTH_BITS'(b[3:0]);
                last = (b[3:0] == 4'd0);
            end else if (!b[5]) begin
                nxt.current_kind      = KIND_MEDIUM;
                nxt.length_accum      = ACC_BITS'(b[2:0]);
                nxt.header_bytes_left = MEDIUM_HDR_BYTES;
            end else if (!b[4]) begin
                nxt.current_kind      = KIND_LONG;
                nxt.length_accum      = '0;
                nxt.header_bytes_left = LONG_HDR_BYTES;
            end else begin
                nxt.current_kind = KIND_CONTROL;
                last = 1'b1;
            end
            if (last && (b == i_empty_atom)) begin
                keep = 1'b0;
            end
        end else if (i_state.header_bytes_left != 2'd0) begin
            nxt.length_accum      = shifted_acc;
            nxt.header_bytes_left = i_state.header_bytes_left - 2'd1;
            if (i_state.header_bytes_left == 2'd1) begin
                nxt.bytes_left = sat_len;
                last = (sat_len == '0);
            end
        end else begin
            nxt.bytes_left = i_state.bytes_left - LENGTH_BITS'(1);
            last = (i_state.bytes_left == LENGTH_BITS'(1));
        end

        // end of payload puts the parser back at a token boundary
        if (i_in.last_byte) begin
            o_state = '{bytes_left: '0, header_bytes_left: 2'd0,
                        length_accum: '0, current_kind: KIND_TINY};
        end else begin
            o_state = nxt;
        end
    end

    assign o_res.out_byte    = b;
    assign o_res.keep        = keep;
    assign o_res.token_first = first;
    assign o_res.token_last  = last;
    assign o_res.token_kind  = nxt.current_kind;
    assign o_res.truncated   = i_in.last_byte && !last;
    assign o_res.stream_end  = i_in.last_byte;

endmodule

[design/tcg_atom_token_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_atom_token_splitter: TCG storage response token splitter
// Marks token boundaries, kind and empty atoms on a payload byte stream.
// ----------------------------------------------------------------------------
// One byte in, one result out, at one byte per clock while input stall is
// low. Each accepted byte is decoded in the cycle it is taken; its result is
// registered in main, or in the skid register while output stall holds main.
// With this two-entry output register, input stall is a registered signal
// and a byte is still taken while one result waits under output stall. The
// empty atom value is written through the always-ready config port; the user
// must write it only while idle, which the block does not enforce.
module tcg_atom_token_splitter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tcgs_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tcgs_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcgs_pkg::BYTE_BITS-1:0]     i_cfg_data
);
    import tcgs_pkg::*;

    logic [BYTE_BITS-1:0] r_empty_atom;
    t_state               r_state;
    t_state               n_state;
    t_out                 res;
    t_out                 r_out;
    t_out                 n_out;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out                 r_skid;
    t_out                 n_skid;
    logic                 r_skid_valid;
    logic                 n_skid_valid;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 out_free;

    tcgs_decode u_decode (
        .i_state      (r_state),
        .i_in         (i_in_data),
        .i_empty_atom (r_empty_atom),
        .o_state      (n_state),
        .o_res        (res)
    );

    assign in_xfer  = i_in_valid && !r_skid_valid;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || out_xfer;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = in_xfer;
            end
        end else if (in_xfer) begin
            // main register held by stall, park the new result
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_atom <= EMPTY_ATOM_RESET;
            r_state      <= '{bytes_left: '0, header_bytes_left: 2'd0,
                              length_accum: '0, current_kind: KIND_TINY};
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_empty_atom <= i_cfg_data;
            end
            if (in_xfer) begin
                r_state <= n_state;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    a_skid_behind_main: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid
    ) else $error("skid entry held without a main result");

    a_end_clears_state: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.last_byte) |=>
            (r_state.bytes_left == '0 && r_state.header_bytes_left == 2'd0)
    ) else $error("state not at token boundary after end of payload");

    a_header_no_data: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state.header_bytes_left != 2'd0) |-> (r_state.bytes_left == '0)
    ) else $error("data count set while length bytes pending");

    a_drop_single_byte: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.keep) |->
            (o_out_data.token_first && o_out_data.token_last)
    ) else $error("dropped byte is not a one-byte token");
`endif

endmodule
